/* rtl/segmented_square_cost_dp_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the segmented square cost unit
// ---------------------------------------------------------------------------
`ifndef SEGMENTED_SQUARE_COST_DP_UNIT_MACROS_SVH
`define SEGMENTED_SQUARE_COST_DP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sscdp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Segmented square cost package
// Shared widths, states and the controller/datapath command struct.
// ---------------------------------------------------------------------------
package sscdp_pkg;
    localparam int MaxItems = 1023;
    localparam int HullDepth = MaxItems + 1;
    localparam int PtrW = $clog2(HullDepth);
    localparam int BackW = $clog2(HullDepth + 1);
    localparam int CntW = $clog2(MaxItems + 1);
    localparam int SumW = 20;
    localparam int ValW = 42;
    localparam int CostW = 41;
    localparam int ProdW = 64;
    localparam logic [1:0] RegCharge = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FRD, ST_FWAIT, ST_FCMP, ST_BEST, ST_BRD, ST_BWAIT,
        ST_BMUL, ST_BCMP, ST_PUSH, ST_OUT
    } state_t;

    typedef struct packed {
        logic take;      // latch input word, start item
        logic skip;      // item beyond limit: repeat last answer
        logic frd;       // read front pair
        logic fcmp;      // evaluate front test
        logic best;      // compute answer from front point
        logic brd;       // read back pair
        logic bmul;      // cross products
        logic bcmp;      // evaluate back test
        logic push;      // push new point
        logic done;      // present result, restart if last
    } cmd_t;

    typedef struct packed {
        logic two_plus;  // deque holds at least two points
        logic fpop;      // front test says drop
        logic bpop;      // back test says drop
        logic full;      // item limit reached
        logic out_busy;  // output register holds an untaken word
    } sts_t;
endpackage

/* rtl/sscdp_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Segmented square cost controller
// Sequences front pops, answer, back pops and push for each word within the item limit.
// ---------------------------------------------------------------------------
module sscdp_ctrl
    import sscdp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = sts.full ? ST_OUT : ST_FRD;
            ST_FRD:   state_next = sts.two_plus ? ST_FWAIT : ST_BEST;
            ST_FWAIT: state_next = ST_FCMP;
            ST_FCMP:  state_next = sts.fpop ? ST_FRD : ST_BEST;
            ST_BEST:  state_next = ST_BRD;
            ST_BRD:   state_next = sts.two_plus ? ST_BWAIT : ST_PUSH;
            ST_BWAIT: state_next = ST_BMUL;
            ST_BMUL:  state_next = ST_BCMP;
            ST_BCMP:  state_next = sts.bpop ? ST_BRD : ST_PUSH;
            ST_PUSH:  state_next = ST_OUT;
            ST_OUT:   if (!sts.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                cmd.skip = in_valid & sts.full;
            end
            ST_FRD:  cmd.frd = 1'b1;
            ST_FCMP: cmd.fcmp = 1'b1;
            ST_BEST: cmd.best = 1'b1;
            ST_BRD:  cmd.brd = 1'b1;
            ST_BMUL: cmd.bmul = 1'b1;
            ST_BCMP: cmd.bcmp = 1'b1;
            ST_PUSH: cmd.push = 1'b1;
            ST_OUT:  cmd.done = !sts.out_busy;
            default: ;
        endcase
    end
endmodule

/* rtl/sscdp_path.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Segmented square cost datapath
// Hull memories, pointers, exact cross-multiplied slope tests and output.
// ---------------------------------------------------------------------------
`include "segmented_square_cost_dp_unit_macros.svh"
module sscdp_path
    import sscdp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [15:0]      charge,
    input  logic [9:0]       item_cost,
    input  logic             last_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CostW-1:0] out_cost,
    output logic             out_last
);
    logic [SumW-1:0] sum_mem [HullDepth];
    logic [ValW-1:0] val_mem [HullDepth];
    logic [SumW-1:0] sa_reg, sb_reg;
    logic [ValW-1:0] va_reg, vb_reg;
    logic [SumW-1:0] s_reg;
    logic [PtrW-1:0] front_reg;
    logic [BackW-1:0] back_reg;
    logic [CntW-1:0] cnt_reg;
    logic [CostW-1:0] best_reg, last_best_reg;
    logic [ValW-1:0] fi_reg;
    logic last_reg, valid_reg, back_mode_reg;
    logic [CostW-1:0] out_cost_reg;
    logic out_last_reg;
    logic [ProdW-1:0] p1_reg, p2_reg;
    logic s1n_reg, s2n_reg, s1z_reg, s2z_reg;
    logic [PtrW-1:0] ra, rb;
    logic [SumW-1:0] s_next;

    assign s_next = s_reg + SumW'(item_cost);

    // read addresses: back pair through the whole back test, else front pair
    always_comb begin
        if (cmd.brd || back_mode_reg) begin
            ra = PtrW'(back_reg - BackW'(2));
            rb = PtrW'(back_reg - BackW'(1));
        end else begin
            ra = front_reg;
            rb = PtrW'(front_reg + PtrW'(1));
        end
    end

    // memories: registered reads, one write port
    always_ff @(posedge aclk) begin
        if (cmd.push && back_reg < BackW'(HullDepth)) begin
            sum_mem[PtrW'(back_reg)] <= s_reg;
            val_mem[PtrW'(back_reg)] <= fi_reg;
        end
        sa_reg <= sum_mem[ra];
        sb_reg <= sum_mem[rb];
        va_reg <= val_mem[ra];
        vb_reg <= val_mem[rb];
    end

    // front point; entry 0 is the point (0,0) and is never stored
    logic [SumW-1:0] sj;
    logic [ValW-1:0] fj;
    assign sj = (front_reg == '0) ? '0 : sa_reg;
    assign fj = (front_reg == '0) ? '0 : va_reg;

    // front test: F_b - F_a <= 2 s (S_b - S_a)
    logic signed [ValW:0] df;
    logic [ProdW-1:0] rhs;
    assign df = $signed({1'b0, vb_reg}) - $signed({1'b0, fj});
    assign rhs = ProdW'({s_reg, 1'b0}) * ProdW'(sb_reg - sj);
    logic fpop;
    assign fpop = df[ValW] || (ProdW'(df) <= rhs);

    logic [SumW-1:0] diff;
    assign diff = s_reg - sj;

    // back test operands
    logic signed [ValW:0] d1, d2;
    logic [SumW-1:0] w1, w2;
    logic [ValW-1:0] vb_eff, va_eff;
    logic [SumW-1:0] sa_eff, sb_eff;
    assign sa_eff = (back_reg == BackW'(2)) && front_reg == '0 ? '0 : sa_reg;
    assign va_eff = (back_reg == BackW'(2)) && front_reg == '0 ? '0 : va_reg;
    assign sb_eff = sb_reg;
    assign vb_eff = vb_reg;
    assign d1 = $signed({1'b0, vb_eff}) - $signed({1'b0, va_eff});
    assign d2 = $signed({1'b0, fi_reg}) - $signed({1'b0, vb_eff});
    assign w1 = s_reg - sb_eff;
    assign w2 = sb_eff - sa_eff;
    logic [ValW-1:0] m1, m2;
    assign m1 = d1[ValW] ? ValW'(-d1) : ValW'(d1);
    assign m2 = d2[ValW] ? ValW'(-d2) : ValW'(d2);

    logic signed [2:0] sx, sy;
    logic bpop;
    always_comb begin
        sx = s1z_reg ? 3'sd0 : (s1n_reg ? -3'sd1 : 3'sd1);
        sy = s2z_reg ? 3'sd0 : (s2n_reg ? -3'sd1 : 3'sd1);
        if (sx != sy) bpop = sx > sy;
        else if (sx == 3'sd0) bpop = 1'b1;
        else if (sx < 3'sd0) bpop = p1_reg <= p2_reg;
        else bpop = p1_reg >= p2_reg;
    end

    // control and arithmetic registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg <= '0;
            front_reg <= '0;
            back_reg <= BackW'(1);
            cnt_reg <= '0;
            valid_reg <= 1'b0;
            back_mode_reg <= 1'b0;
            last_best_reg <= '0;
        end else begin
            if (valid_reg && out_ready) valid_reg <= 1'b0;
            if (cmd.take) begin
                last_reg <= last_item;
                if (cmd.skip) begin
                    best_reg <= last_best_reg;
                end else begin
                    s_reg <= s_next;
                    cnt_reg <= cnt_reg + CntW'(1);
                end
            end
            if (cmd.fcmp && fpop) front_reg <= front_reg + PtrW'(1);
            if (cmd.best) begin
                best_reg <= CostW'(fj - ValW'(sj) * ValW'(sj)
                    + ValW'(diff) * ValW'(diff) + ValW'(charge));
                fi_reg <= (fj - ValW'(sj) * ValW'(sj) + ValW'(diff) * ValW'(diff)
                    + ValW'(charge)) + ValW'(s_reg) * ValW'(s_reg);
            end
            if (cmd.brd) back_mode_reg <= 1'b1;
            if (cmd.bmul) begin
                p1_reg <= ProdW'(m1) * ProdW'(w1);
                p2_reg <= ProdW'(m2) * ProdW'(w2);
                s1z_reg <= (d1 == '0) || (w1 == '0);
                s2z_reg <= (d2 == '0) || (w2 == '0);
                s1n_reg <= d1[ValW];
                s2n_reg <= d2[ValW];
            end
            if (cmd.bcmp && bpop) back_reg <= back_reg - BackW'(1);
            if (cmd.push && back_reg < BackW'(HullDepth)) back_reg <= back_reg + BackW'(1);
            if (cmd.push) begin
                last_best_reg <= best_reg;
                back_mode_reg <= 1'b0;
            end
            if (cmd.done) begin
                valid_reg <= 1'b1;
                out_cost_reg <= best_reg;
                out_last_reg <= last_reg;
                if (last_reg) begin
                    s_reg <= '0;
                    front_reg <= '0;
                    back_reg <= BackW'(1);
                    cnt_reg <= '0;
                    last_best_reg <= '0;
                end
            end
        end
    end

    assign sts.two_plus = (back_reg - BackW'(front_reg)) >= BackW'(2);
    assign sts.fpop = fpop;
    assign sts.bpop = bpop;
    assign sts.full = cnt_reg >= CntW'(MaxItems);
    assign sts.out_busy = valid_reg && !out_ready;
    assign out_valid = valid_reg;
    assign out_cost = out_cost_reg;
    assign out_last = out_last_reg;

    `SSC_ASSERT_IMP(a_front_le_back, aclk, aresetn, 1'b1, BackW'(front_reg) < back_reg)
    `SSC_ASSERT_NXT(a_done_valid, aclk, aresetn, cmd.done, valid_reg)
    `SSC_ASSERT_IMP(a_no_take_busy, aclk, aresetn, cmd.take, !cmd.done)
endmodule

/* rtl/segmented_square_cost_dp_unit.sv */
`timescale 1ns / 1ps
// Each accepted word runs front pops (read, test), the answer, back pops (read,
// cross-multiply, test) and the push, then waits for a free output register; a new
// word is accepted only after that. Items past the item limit skip the hull work and
// repeat the last answer. Reset (aresetn low, synchronous) clears the charge register,
// the sums and pointers; the hull needs no clearing.
// ---------------------------------------------------------------------------
// Segmented square cost unit
// Minimum cost of cutting a stream into segments via a monotone hull deque.
// ---------------------------------------------------------------------------
module segmented_square_cost_dp_unit
    import sscdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] item_cost, rest zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [40:0] best_cost, rest zero
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] charge_reg;
    cmd_t cmd;
    sts_t sts;
    logic [CostW-1:0] cost;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) charge_reg <= '0;
        else if (psel && penable && pwrite && paddr == RegCharge) charge_reg <= pwdata[15:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == RegCharge) ? {16'd0, charge_reg} : 32'd0;

    sscdp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    sscdp_path u_path (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .charge(charge_reg),
        .item_cost(s_tdata[9:0]), .last_item(s_tlast), .out_valid(m_tvalid),
        .out_ready(m_tready), .out_cost(cost), .out_last(m_tlast)
    );

    assign m_tdata = {7'd0, cost};
endmodule
